### design/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the GB2312 glyph fetch unit
// Item, result, state and register structs; byte class limits, glyph sizes
// and register reset values.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Display defaults
  localparam int DEF_SCREEN_WIDTH = 128;
  localparam int DEF_SCREEN_PAGES = 8;

  // Byte classes
  localparam logic [7:0] HZ_LEAD_LO   = 8'hB0;
  localparam logic [7:0] HZ_LEAD_HI   = 8'hF7;
  localparam logic [7:0] SYM_LEAD_LO  = 8'hA1;
  localparam logic [7:0] SYM_LEAD_HI  = 8'hA3;
  localparam logic [7:0] TRAIL_LO     = 8'hA1;
  localparam logic [7:0] ASCII_LO     = 8'h20;
  localparam logic [7:0] ASCII_HI     = 8'h7E;
  localparam logic [7:0] TERMINATOR   = 8'h00;
  localparam logic [6:0] ROW_CELLS    = 7'd94;

  // Glyph sizes: drawn width in columns and ROM byte count
  localparam logic [4:0] HZ_WIDTH     = 5'd16;
  localparam logic [4:0] A16_WIDTH    = 5'd8;
  localparam logic [4:0] A5_WIDTH     = 5'd6;
  localparam logic [5:0] HZ_COUNT     = 6'd32;
  localparam logic [5:0] A16_COUNT    = 6'd16;
  localparam logic [5:0] A5_COUNT     = 6'd5;

  // Register reset values
  localparam logic [15:0] RST_HANZI_OFFSET     = 16'd846;
  localparam logic [23:0] RST_ASCII16_BASE     = 24'h03CF80;
  localparam logic [23:0] RST_SMALL_GLYPH_BASE = 24'h03BFC0;

  // Register indexes
  typedef enum logic [1:0] {
    REG_SMALL_FONT       = 2'd0,
    REG_HANZI_OFFSET     = 2'd1,
    REG_ASCII16_BASE     = 2'd2,
    REG_SMALL_GLYPH_BASE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    GK_HANZI   = 2'd0,
    GK_ASCII16 = 2'd1,
    GK_ASCII5  = 2'd2,
    GK_END     = 2'd3
  } glyph_kind_t;

  typedef struct packed {
    logic        small_font_mode;
    logic [15:0] hanzi_index_offset;
    logic [23:0] ascii16_base;
    logic [23:0] small_glyph_base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
    logic [3:0] start_page;
    logic [7:0] start_column;
  } item_t;

  typedef struct packed {
    glyph_kind_t kind;
    logic [23:0] rom_address;
    logic [5:0]  read_count;
    logic [3:0]  page;
    logic [7:0]  column;
  } result_t;

  typedef struct packed {
    logic [7:0] pending_lead;
    logic       pending_valid;
    logic [7:0] current_column;
    logic [3:0] current_page;
    logic       string_active;
    logic       halted;
  } state_t;

endpackage

### design/gtg_glyph_core.sv
// ----------------------------------------------------------------------------
// gtg_glyph_core: byte classification, ROM addressing and string state
// Holds the string state and, for the byte in the input register, works
// out the fetch command and the next state in one pass.
// ----------------------------------------------------------------------------
module gtg_glyph_core #(
  parameter int SCREEN_WIDTH = gtg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_PAGES = gtg_pkg::DEF_SCREEN_PAGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  gtg_pkg::item_t   item,
  input  gtg_pkg::cfg_t    cfg,
  output gtg_pkg::result_t result,
  output logic             emit
);

  localparam logic [3:0] PAGES_SMALL = 4'(SCREEN_PAGES);
  localparam logic [3:0] PAGES_WIDE  = 4'(SCREEN_PAGES - 1);
  localparam logic [8:0] WIDTH_LIM   = 9'(SCREEN_WIDTH);

  gtg_pkg::state_t state;
  gtg_pkg::state_t state_next;

  logic [7:0]  b;
  logic [3:0]  max_page;
  logic        is_ascii;
  logic        is_lead;
  logic        want;
  logic [4:0]  gw;
  logic [8:0]  col_limit;
  logic [6:0]  row;
  logic [12:0] row_base;
  logic [16:0] hz_index;
  logic [7:0]  trail;
  logic [15:0] hz_offset;
  gtg_pkg::glyph_kind_t kind;
  logic [23:0] addr;
  logic [5:0]  cnt;

  always_comb begin
    b          = item.text_byte;
    state_next = state;
    emit       = 1'b0;
    want       = 1'b0;
    kind       = gtg_pkg::GK_END;
    addr       = '0;
    cnt        = '0;
    gw         = gtg_pkg::A5_WIDTH;
    max_page   = cfg.small_font_mode ? PAGES_SMALL : PAGES_WIDE;
    is_ascii   = (b >= gtg_pkg::ASCII_LO) && (b <= gtg_pkg::ASCII_HI);
    is_lead    = ((b >= gtg_pkg::HZ_LEAD_LO) && (b <= gtg_pkg::HZ_LEAD_HI)) ||
                 ((b >= gtg_pkg::SYM_LEAD_LO) && (b <= gtg_pkg::SYM_LEAD_HI));

    // hanzi index from the held lead and this byte as trail
    trail     = b - gtg_pkg::TRAIL_LO;
    if (state.pending_lead >= gtg_pkg::HZ_LEAD_LO) begin
      row       = 7'(state.pending_lead - gtg_pkg::HZ_LEAD_LO);
      hz_offset = cfg.hanzi_index_offset;
    end else begin
      row       = 7'(state.pending_lead - gtg_pkg::SYM_LEAD_LO);
      hz_offset = '0;
    end
    row_base = 13'(row) * 13'(gtg_pkg::ROW_CELLS);
    hz_index = 17'(row_base) + 17'(trail) + 17'(hz_offset);

    if (item.first_byte) begin
      state_next.pending_valid = 1'b0;
      state_next.pending_lead  = '0;
      state_next.halted        = 1'b0;
      state_next.string_active = (item.start_page >= 4'd1) && (item.start_page <= max_page) &&
                                 (item.start_column >= 8'd1) &&
                                 ({1'b0, item.start_column} <= WIDTH_LIM);
      state_next.current_page   = state_next.string_active ? item.start_page : '0;
      state_next.current_column = state_next.string_active ? item.start_column : '0;
    end

    if (state_next.string_active) begin
      if (b == gtg_pkg::TERMINATOR) begin
        state_next.pending_valid = 1'b0;
        state_next.pending_lead  = '0;
        state_next.string_active = 1'b0;
        state_next.halted        = 1'b0;
        emit = 1'b1;
      end else if (state_next.halted) begin
        state_next.pending_valid = 1'b0;
        state_next.pending_lead  = '0;
      end else if (cfg.small_font_mode) begin
        state_next.pending_valid = 1'b0;
        state_next.pending_lead  = '0;
        if (is_ascii) begin
          want = 1'b1;
          kind = gtg_pkg::GK_ASCII5;
          addr = {13'd0, 8'(b - gtg_pkg::ASCII_LO), 3'd0} + cfg.small_glyph_base;
          cnt  = gtg_pkg::A5_COUNT;
          gw   = gtg_pkg::A5_WIDTH;
        end
      end else if (state_next.pending_valid && (b >= gtg_pkg::TRAIL_LO)) begin
        state_next.pending_valid = 1'b0;
        state_next.pending_lead  = '0;
        want = 1'b1;
        kind = gtg_pkg::GK_HANZI;
        addr = {2'd0, hz_index, 5'd0};
        cnt  = gtg_pkg::HZ_COUNT;
        gw   = gtg_pkg::HZ_WIDTH;
      end else begin
        // a held lead without a valid trail is dropped, byte taken afresh
        state_next.pending_valid = 1'b0;
        state_next.pending_lead  = '0;
        if (is_lead) begin
          state_next.pending_valid = 1'b1;
          state_next.pending_lead  = b;
        end else if (is_ascii) begin
          want = 1'b1;
          kind = gtg_pkg::GK_ASCII16;
          addr = {12'd0, 8'(b - gtg_pkg::ASCII_LO), 4'd0} + cfg.ascii16_base;
          cnt  = gtg_pkg::A16_COUNT;
          gw   = gtg_pkg::A16_WIDTH;
        end
      end
    end

    // placement: overrun halts glyph output until the terminator or a new first byte
    col_limit = WIDTH_LIM - 9'(gw) + 9'd1;
    if (want) begin
      if ({1'b0, state_next.current_column} > col_limit) begin
        state_next.halted = 1'b1;
      end else begin
        emit = 1'b1;
        state_next.current_column = state_next.current_column + 8'(gw);
      end
    end

    result.kind        = kind;
    result.rom_address = addr;
    result.read_count  = cnt;
    result.page        = (kind == gtg_pkg::GK_END) ? 4'd0 : state_next.current_page;
    result.column      = (kind == gtg_pkg::GK_END) ? 8'd0 : state.current_column;
    if (item.first_byte && (kind != gtg_pkg::GK_END)) begin
      result.column = item.start_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

### design/gb2312_text_to_glyph_fetch_unit.sv
// ----------------------------------------------------------------------------
// gb2312_text_to_glyph_fetch_unit: GB2312 text to font ROM fetch commands
// One text byte per transfer in; one glyph fetch command or end marker out.
//
//   channel  handshake             payload
//   -------  --------------------  ---------------------------------------
//   in       in_valid / in_ready   text_byte first_byte start_page
//                                  start_column
//   out      out_valid / out_ready glyph_kind rom_address read_count
//                                  glyph_page glyph_column
//   cfg      cfg_write             cfg_index cfg_data (no read-back)
//
// One byte per cycle sustained while out_ready is high. A byte sits in the
// input register and its command is loaded into the output register once
// that register is empty or being taken, so out_valid follows the input
// register. Bytes that give no command still take their slot.
// Stalls on out back up through the input register. Reset is synchronous and
// clears handshake and string state; registers return to their defaults.
// ----------------------------------------------------------------------------
module gb2312_text_to_glyph_fetch_unit #(
  parameter int SCREEN_WIDTH = gtg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_PAGES = gtg_pkg::DEF_SCREEN_PAGES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // text bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        first_byte,
  input  logic [3:0]  start_page,
  input  logic [7:0]  start_column,
  // fetch commands
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  glyph_kind,
  output logic [23:0] rom_address,
  output logic [5:0]  read_count,
  output logic [3:0]  glyph_page,
  output logic [7:0]  glyph_column
);

  gtg_pkg::cfg_t    cfg;
  gtg_pkg::item_t   item;
  logic             in_full;
  logic             advance;
  gtg_pkg::result_t res_comb;
  gtg_pkg::result_t res;
  logic             emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.small_font_mode    <= 1'b0;
      cfg.hanzi_index_offset <= gtg_pkg::RST_HANZI_OFFSET;
      cfg.ascii16_base       <= gtg_pkg::RST_ASCII16_BASE;
      cfg.small_glyph_base   <= gtg_pkg::RST_SMALL_GLYPH_BASE;
    end else if (cfg_write) begin
      unique case (gtg_pkg::reg_index_t'(cfg_index))
        gtg_pkg::REG_SMALL_FONT:       cfg.small_font_mode    <= cfg_data[0];
        gtg_pkg::REG_HANZI_OFFSET:     cfg.hanzi_index_offset <= cfg_data[15:0];
        gtg_pkg::REG_ASCII16_BASE:     cfg.ascii16_base       <= cfg_data;
        gtg_pkg::REG_SMALL_GLYPH_BASE: cfg.small_glyph_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.text_byte    <= text_byte;
      item.first_byte   <= first_byte;
      item.start_page   <= start_page;
      item.start_column <= start_column;
    end
  end

  gtg_glyph_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_PAGES (SCREEN_PAGES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (res_comb),
    .emit    (emit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_comb;
    end
  end

  assign glyph_kind   = res.kind;
  assign rom_address  = res.rom_address;
  assign read_count   = res.read_count;
  assign glyph_page   = res.page;
  assign glyph_column = res.column;

  // checks
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (glyph_kind == gtg_pkg::GK_END) |->
      (rom_address == 24'd0) && (read_count == 6'd0) && (glyph_column == 8'd0))
    else $error("end marker carries nonzero fields");

  a_hanzi_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && (glyph_kind == gtg_pkg::GK_HANZI) |->
      (read_count == gtg_pkg::HZ_COUNT) && (rom_address[4:0] == 5'd0))
    else $error("16x16 fetch misaligned or wrong count");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("emitted command lost");

  a_column_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (glyph_kind != gtg_pkg::GK_END) |->
      (glyph_column != 8'd0) && ({1'b0, glyph_column} <= 9'(SCREEN_WIDTH)))
    else $error("glyph placed outside the screen");

endmodule
